// ===== hw/rtl/p422uv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p422uv_pkg
// Shared types, register map and defaults for the packed 4:2:2 unpacker
// with vertical flip.
// ----------------------------------------------------------------------------
package p422uv_pkg;

   localparam int SAMPLE_W   = 10;
   localparam int ROW_W      = 11;
   localparam int COL_W      = 10;
   localparam int DIM_W      = 12;
   localparam int MODE_W     = 2;
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int REG_IDX_W  = 2;

   localparam int DEF_MAX_WIDTH  = 2048;
   localparam int DEF_MAX_HEIGHT = 2048;

   // hardware caps from the counter widths
   localparam int PAIR_CAP = 1024;
   localparam int LINE_CAP = 2048;

   // register indexes
   localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_BIT_DEPTH    = 2'd2;

   // depth mode codes
   localparam logic [MODE_W-1:0] DEPTH_8  = 2'd0;
   localparam logic [MODE_W-1:0] DEPTH_10 = 2'd1;

   localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = 12'd1920;
   localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = 12'd1080;
   localparam logic [MODE_W-1:0] RST_BIT_DEPTH    = DEPTH_10;

   typedef struct packed {
      logic [7:0] byte_zero;
      logic [7:0] byte_one;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
   } req_payload_type;

   typedef struct packed {
      logic [ROW_W-1:0]    dest_row;
      logic [COL_W-1:0]    pair_column;
      logic [SAMPLE_W-1:0] chroma_u;
      logic [SAMPLE_W-1:0] luma_first;
      logic [SAMPLE_W-1:0] chroma_v;
      logic [SAMPLE_W-1:0] luma_second;
      logic                frame_end;
      logic                unsupported;
   } rsp_payload_type;

   typedef struct packed {
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
      logic [MODE_W-1:0] bit_depth_mode;
      logic              restart;
   } cfg_type;

   typedef struct packed {
      logic [ROW_W-1:0] dest_row;
      logic [COL_W-1:0] pair_column;
      logic             frame_end;
   } pos_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] chroma_u;
      logic [SAMPLE_W-1:0] luma_first;
      logic [SAMPLE_W-1:0] chroma_v;
      logic [SAMPLE_W-1:0] luma_second;
      logic                unsupported;
   } samples_type;

endpackage

// ===== hw/rtl/p422uv_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p422uv_csr
// APB register block: frame width, frame height and bit depth mode. Any
// write to a listed register restarts the frame counters.
// ----------------------------------------------------------------------------
module p422uv_csr
   import p422uv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIM_W-1:0]     height_ff, height_in;
   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic                 restart_in;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_W-1:2];

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      mode_in    = mode_ff;
      restart_in = 1'b0;
      if (wr_en) begin
         case (idx)
            REG_FRAME_WIDTH: begin
               width_in   = pwdata[DIM_W-1:0];
               restart_in = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in  = pwdata[DIM_W-1:0];
               restart_in = 1'b1;
            end
            REG_BIT_DEPTH: begin
               mode_in    = pwdata[MODE_W-1:0];
               restart_in = 1'b1;
            end
            default: restart_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= RST_FRAME_WIDTH;
         height_ff  <= RST_FRAME_HEIGHT;
         mode_ff    <= RST_BIT_DEPTH;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         mode_ff    <= mode_in;
      end
   end

   always_comb begin
      case (idx)
         REG_FRAME_WIDTH:  prdata = DATA_W'(width_ff);
         REG_FRAME_HEIGHT: prdata = DATA_W'(height_ff);
         REG_BIT_DEPTH:    prdata = DATA_W'(mode_ff);
         default:          prdata = '0;
      endcase
   end

   // restart is the write strobe itself so counters clear at the same edge
   assign cfg.frame_width    = width_ff;
   assign cfg.frame_height   = height_ff;
   assign cfg.bit_depth_mode = mode_ff;
   assign cfg.restart        = restart_in;

endmodule

// ===== hw/rtl/p422uv_count.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p422uv_count
// Pair and line counters. Gives the pair column, flipped destination row
// and frame-end mark of the beat being accepted.
// ----------------------------------------------------------------------------
module p422uv_count
   import p422uv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic    clock,
   input  logic    reset,
   input  cfg_type cfg,
   input  logic    advance,
   output pos_type pos
);

   localparam int PairLimA = (MAX_WIDTH / 2 > PAIR_CAP) ? PAIR_CAP : MAX_WIDTH / 2;
   localparam int PairLimI = (PairLimA < 1) ? 1 : PairLimA;
   localparam int LineLimA = (MAX_HEIGHT > LINE_CAP) ? LINE_CAP : MAX_HEIGHT;
   localparam int LineLimI = (LineLimA < 1) ? 1 : LineLimA;
   localparam logic [COL_W:0] PAIR_LIM = (COL_W + 1)'(PairLimI);
   localparam logic [DIM_W-1:0] LINE_LIM = DIM_W'(LineLimI);

   logic [COL_W-1:0] pair_ff, pair_in;
   logic [ROW_W-1:0] line_ff, line_in;
   logic [COL_W:0]   half;
   logic [COL_W:0]   pairs;
   logic [DIM_W-1:0] lines;
   logic [COL_W-1:0] pair_now;
   logic [ROW_W-1:0] line_now;
   logic             last_pair;
   logic             last_line;

   always_comb begin
      half = cfg.frame_width[DIM_W-1:1];
      if (half == '0) begin
         pairs = (COL_W + 1)'(1);
      end else if (half > PAIR_LIM) begin
         pairs = PAIR_LIM;
      end else begin
         pairs = half;
      end
      if (cfg.frame_height == '0) begin
         lines = DIM_W'(1);
      end else if (cfg.frame_height > LINE_LIM) begin
         lines = LINE_LIM;
      end else begin
         lines = cfg.frame_height;
      end

      pair_now  = ({1'b0, pair_ff} >= pairs) ? '0 : pair_ff;
      line_now  = ({1'b0, line_ff} >= lines) ? '0 : line_ff;
      last_pair = (({1'b0, pair_now} + (COL_W + 1)'(1)) == pairs);
      last_line = (({1'b0, line_now} + DIM_W'(1)) == lines);

      pos.dest_row    = ROW_W'(lines - DIM_W'(1) - {1'b0, line_now});
      pos.pair_column = pair_now;
      pos.frame_end   = last_pair && last_line;

      pair_in = pair_ff;
      line_in = line_ff;
      if (cfg.restart) begin
         pair_in = '0;
         line_in = '0;
      end else if (advance) begin
         if (last_pair) begin
            pair_in = '0;
            line_in = last_line ? '0 : line_now + ROW_W'(1);
         end else begin
            pair_in = pair_now + COL_W'(1);
            line_in = line_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
         line_ff <= '0;
      end else begin
         pair_ff <= pair_in;
         line_ff <= line_in;
      end
   end

endmodule

// ===== hw/rtl/p422uv_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p422uv_unpack
// Slices one pixel-pair group into U, Y, V, Y samples for the selected
// bit depth.
// ----------------------------------------------------------------------------
module p422uv_unpack
   import p422uv_pkg::*;
(
   input  logic [MODE_W-1:0] mode,
   input  req_payload_type   beat,
   output samples_type       smp
);

   always_comb begin
      smp = '0;
      case (mode)
         DEPTH_8: begin
            smp.chroma_u    = SAMPLE_W'(beat.byte_zero);
            smp.luma_first  = SAMPLE_W'(beat.byte_one);
            smp.chroma_v    = SAMPLE_W'(beat.byte_two);
            smp.luma_second = SAMPLE_W'(beat.byte_three);
         end
         DEPTH_10: begin
            smp.chroma_u    = {beat.byte_zero, beat.byte_one[7:6]};
            smp.luma_first  = {beat.byte_one[5:0], beat.byte_two[7:4]};
            smp.chroma_v    = {beat.byte_two[3:0], beat.byte_three[7:2]};
            smp.luma_second = {beat.byte_three[1:0], beat.byte_four};
         end
         default: smp.unsupported = 1'b1;
      endcase
   end

endmodule

// ===== hw/rtl/packed_422_unpack_vflip_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_422_unpack_vflip_core
// Packed 4:2:2 pixel-pair unpacker with vertical flip: one pair group in,
// four samples out with flipped row, pair column and frame-end mark.
//
//   channel   ports                         direction   beat
//   req       req_valid req_stall req_data  in          one pair group
//   rsp       rsp_valid rsp_stall rsp_data  out         one unpacked pair
//   csr       psel penable pwrite paddr ... in/out      register access
//
// one beat per cycle sustained while rsp_stall is low; an accepted beat
// reaches rsp_valid through the input register, then the result register
// synchronous reset clears counters, stage valids and config registers; stage data is not reset
// a stalled result holds the result stage and a full input stage; req_stall rises only when both are full
// ----------------------------------------------------------------------------
module packed_422_unpack_vflip_core
   import p422uv_pkg::*;
#(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready
);

   cfg_type         cfg;
   pos_type         pos;
   samples_type     smp;
   logic            req_take;
   logic            a_load;
   logic            b_load;

   logic            a_valid_ff, a_valid_in;
   req_payload_type a_beat_ff, a_beat_in;
   pos_type         a_pos_ff, a_pos_in;
   logic            b_valid_ff, b_valid_in;
   rsp_payload_type b_data_ff, b_data_in;

   p422uv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   p422uv_count #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_count (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .advance (req_take),
      .pos     (pos)
   );

   p422uv_unpack u_unpack (
      .mode (cfg.bit_depth_mode),
      .beat (a_beat_ff),
      .smp  (smp)
   );

   assign b_load    = !b_valid_ff || !rsp_stall;
   assign a_load    = !a_valid_ff || b_load;
   assign req_stall = !a_load;
   assign req_take  = req_valid && a_load;

   always_comb begin
      a_valid_in = a_valid_ff;
      a_beat_in  = a_beat_ff;
      a_pos_in   = a_pos_ff;
      if (a_load) begin
         a_valid_in = req_valid;
         a_beat_in  = req_data;
         a_pos_in   = pos;
      end

      b_valid_in = b_valid_ff;
      b_data_in  = b_data_ff;
      if (b_load) begin
         b_valid_in            = a_valid_ff;
         b_data_in.dest_row    = a_pos_ff.dest_row;
         b_data_in.pair_column = a_pos_ff.pair_column;
         b_data_in.frame_end   = a_pos_ff.frame_end;
         b_data_in.chroma_u    = smp.chroma_u;
         b_data_in.luma_first  = smp.luma_first;
         b_data_in.chroma_v    = smp.chroma_v;
         b_data_in.luma_second = smp.luma_second;
         b_data_in.unsupported = smp.unsupported;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_beat_ff <= a_beat_in;
      a_pos_ff  <= a_pos_in;
      b_data_ff <= b_data_in;
   end

   assign rsp_valid = b_valid_ff;
   assign rsp_data  = b_data_ff;

   // last pair of the frame always lands on flipped row zero
   a_frame_end_row : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_data_ff.frame_end |-> b_data_ff.dest_row == '0)
      else $error("frame end not on row zero");

   a_unsup_zero : assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && b_data_ff.unsupported |->
         b_data_ff.chroma_u == '0 && b_data_ff.luma_first == '0 &&
         b_data_ff.chroma_v == '0 && b_data_ff.luma_second == '0)
      else $error("unsupported beat carries samples");

   a_stage_hold : assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && !b_load |=> a_valid_ff && $stable(a_beat_ff) && $stable(a_pos_ff))
      else $error("input stage lost a held beat");

   a_no_take_full : assert property (@(posedge clock) disable iff (reset)
      a_valid_ff && b_valid_ff && rsp_stall |-> !req_take)
      else $error("beat taken while pipeline full");

endmodule
